[rtl/core/ssti_pkg.sv]
// ----------------------------------------------------------------------------
// ssti_pkg
// Shared constants and types for the staged Simpson tracker integrator.
// ----------------------------------------------------------------------------
package ssti_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int DEF_MAX_TRACKERS = 8;
    localparam int DATA_W           = 32;
    localparam int PARAM_W          = 31;
    localparam int NUM_W            = 36;
    localparam int RES_W            = 36;

    localparam logic [PARAM_W-1:0] DEF_STEP = 31'd65536;

    localparam logic [0:0] REQ_LOAD = 1'b0;
    localparam logic [0:0] REQ_STEP = 1'b1;

    localparam logic [0:0] REG_TIME_STEP     = 1'b0;
    localparam logic [0:0] REG_INV_TIME_STEP = 1'b1;

    typedef logic [1:0] den_t;
    localparam den_t DEN_1 = 2'd0;
    localparam den_t DEN_2 = 2'd1;
    localparam den_t DEN_3 = 2'd2;
    localparam den_t DEN_6 = 2'd3;

    typedef struct packed {
        logic start;
        den_t den;
    } scl_req_t;

    typedef logic [2:0][DATA_W-1:0] vec3_t;

    typedef struct packed {
        vec3_t older;
        vec3_t prev;
    } vel_row_t;

endpackage

[rtl/core/ssti_scale.sv]
// ----------------------------------------------------------------------------
// ssti_scale
// Multi-cycle scaler: round(num * mult / (den * 2^FRAC_BITS)), ties away
// from zero, magnitude clamped where the caller saturates anyway.
// ----------------------------------------------------------------------------
module ssti_scale (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ssti_pkg::scl_req_t                  req,
    input  logic signed [ssti_pkg::NUM_W-1:0]   num,
    input  logic [ssti_pkg::PARAM_W-1:0]        mult,
    output logic                                busy,
    output logic signed [ssti_pkg::RES_W-1:0]   result
);

    localparam int HALF_W    = ssti_pkg::NUM_W / 2;
    localparam int PROD_W    = HALF_W + ssti_pkg::PARAM_W;
    localparam int SUM_W     = PROD_W + HALF_W;
    localparam int CLAMP_W   = ssti_pkg::RES_W - 1;
    localparam int QUO_W     = 40;
    localparam int DIV_STEPS = QUO_W / 8;
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;

    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_LO   = 3'd1;
    localparam logic [2:0] SC_HI   = 3'd2;
    localparam logic [2:0] SC_SUM  = 3'd3;
    localparam logic [2:0] SC_DIV  = 3'd4;
    localparam logic [2:0] SC_SIGN = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [2:0]                    cnt_reg;
    logic [ssti_pkg::NUM_W-1:0]    mag_reg;
    logic [ssti_pkg::NUM_W-1:0]    num_mag;
    logic                          neg_reg;
    logic [ssti_pkg::PARAM_W-1:0]  mult_reg;
    ssti_pkg::den_t                den_reg;
    logic [PROD_W-1:0]             prod_lo_reg, prod_hi_reg, product;
    logic [HALF_W-1:0]             mul_a;
    logic [SUM_W-1:0]              rnd, sum, shifted;
    logic [QUO_W-1:0]              quo_reg;
    logic [1:0]                    rem_reg;
    logic [2:0]                    den_val;
    logic                          div3, even;
    logic [9:0]                    x, r10;
    logic [20:0]                   recip;
    logic [7:0]                    q8;
    logic [ssti_pkg::RES_W-1:0]    mag_out;

    assign busy    = (state_reg != SC_IDLE);
    assign num_mag = num[ssti_pkg::NUM_W-1] ? (~num + 1'b1) : num;

    always_comb begin
        unique case (den_reg)
            ssti_pkg::DEN_1: den_val = 3'd1;
            ssti_pkg::DEN_2: den_val = 3'd2;
            ssti_pkg::DEN_3: den_val = 3'd3;
            default:         den_val = 3'd6;
        endcase
    end

    assign div3 = (den_reg == ssti_pkg::DEN_3) || (den_reg == ssti_pkg::DEN_6);
    assign even = (den_reg == ssti_pkg::DEN_2) || (den_reg == ssti_pkg::DEN_6);

    assign mul_a   = (state_reg == SC_LO) ? mag_reg[HALF_W-1:0]
                                          : mag_reg[ssti_pkg::NUM_W-1:HALF_W];
    assign product = PROD_W'(mul_a) * PROD_W'(mult_reg);

    assign rnd     = SUM_W'(den_val) << (ssti_pkg::FRAC_BITS - 1);
    assign sum     = {prod_hi_reg, {HALF_W{1'b0}}} + SUM_W'(prod_lo_reg) + rnd;
    assign shifted = even ? (sum >> (ssti_pkg::FRAC_BITS + 1))
                          : (sum >> ssti_pkg::FRAC_BITS);

    // radix-256 long division by three, top chunk first
    assign x     = {rem_reg, quo_reg[QUO_W-1 -: 8]};
    assign recip = 21'(x) * 21'(RECIP3);
    assign q8    = recip[RECIP3_SH +: 8];
    assign r10   = x - {1'b0, q8, 1'b0} - {2'b0, q8};

    assign mag_out = {1'b0, quo_reg[CLAMP_W-1:0]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE: if (req.start) state_next = SC_LO;
            SC_LO:   state_next = SC_HI;
            SC_HI:   state_next = SC_SUM;
            SC_SUM:  state_next = SC_DIV;
            SC_DIV:  if (cnt_reg == 3'(DIV_STEPS - 1)) state_next = SC_SIGN;
            SC_SIGN: state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SC_SUM) begin
                cnt_reg <= '0;
            end else if (state_reg == SC_DIV) begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == SC_IDLE && req.start) begin
            mag_reg  <= num_mag;
            neg_reg  <= num[ssti_pkg::NUM_W-1];
            mult_reg <= mult;
            den_reg  <= req.den;
        end
        if (state_reg == SC_LO) prod_lo_reg <= product;
        if (state_reg == SC_HI) prod_hi_reg <= product;
        if (state_reg == SC_SUM) begin
            rem_reg <= '0;
            if (|shifted[SUM_W-1:CLAMP_W]) begin
                quo_reg <= QUO_W'({CLAMP_W{1'b1}});
            end else begin
                quo_reg <= QUO_W'(shifted[CLAMP_W-1:0]);
            end
        end
        if (state_reg == SC_DIV) begin
            if (div3) begin
                quo_reg <= {quo_reg[QUO_W-9:0], q8};
                rem_reg <= r10[1:0];
            end else begin
                quo_reg <= {quo_reg[QUO_W-9:0], quo_reg[QUO_W-1 -: 8]};
            end
        end
        if (state_reg == SC_SIGN) begin
            result <= neg_reg ? $signed(~mag_out + 1'b1) : $signed(mag_out);
        end
    end

endmodule

[rtl/core/staged_simpson_tracker_integrator_core.sv]
// ----------------------------------------------------------------------------
// staged_simpson_tracker_integrator_core
// Three-axis tracker position integrator with staged Simpson increments.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per request. tuser[0] selects load (0) or
// step (1). Load words write the start position, clear the velocity history
// and are taken at one per cycle while no step is in flight, with no result.
// Step words read the tracker row from the position and velocity memories,
// run six scalers in parallel (acceleration and increment per axis) and
// write the row back. A step holds off the input until its writeback,
// where its result is registered; the scaler sequence sets the wait: two
// partial products, a rounding add and five radix-256 steps of the division
// by three, which run for every denominator, then a sign step.
// Words naming a tracker at or above MAX_TRACKERS are taken and dropped.
// The result sits in an output register; a stalled receiver holds it and
// load words keep flowing, while the next step waits at writeback.
// Reset clears control and the velocity valid bits (history reads as zero);
// positions hold nothing until loaded. No clearing pass is needed.
// Config writes (cfg_*) are always ready; index 0 time_step, 1 inverse.
// ----------------------------------------------------------------------------
module staged_simpson_tracker_integrator_core #(
    parameter int MAX_TRACKERS = ssti_pkg::DEF_MAX_TRACKERS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tracker, step_number, shift_x, shift_y, shift_z, start_x, start_y,
    // start_z, zero pad
    input  logic [231:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tracker_out, position_x, position_y, position_z, accel_x, accel_y,
    // accel_z, zero pad
    output logic [199:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int ADDR_W = (MAX_TRACKERS > 1) ? $clog2(MAX_TRACKERS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    function automatic logic [31:0] sat37(input logic [36:0] val);
        if (val[36:31] == {6{val[31]}}) begin
            return val[31:0];
        end
        return val[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic [1:0]                     state_reg, state_next;
    logic [ssti_pkg::PARAM_W-1:0]   dt_reg, inv_reg;
    logic [MAX_TRACKERS-1:0]        vel_valid_reg;
    logic                           m_tvalid_reg;
    logic [199:0]                   m_tdata_reg;

    logic [95:0]                    start_w;
    logic [6:0]                     trk_ext;
    logic                           in_acc, in_range, is_load, is_step, wb, unit_start;
    logic [ADDR_W-1:0]              in_addr, addr_reg;
    logic [2:0]                     trk_reg;
    logic [31:0]                    step_reg;
    ssti_pkg::vec3_t                shift_reg;
    ssti_pkg::den_t                 inc_den;
    logic                           vel_valid_rd;
    logic [2:0]                     busy_acc, busy_inc;

    ssti_pkg::vec3_t                pos_mem [MAX_TRACKERS];
    ssti_pkg::vel_row_t             vel_mem [MAX_TRACKERS];
    ssti_pkg::vec3_t                pos_rd_reg;
    ssti_pkg::vel_row_t             vel_rd_reg;
    logic                           pos_we;
    logic [ADDR_W-1:0]              pos_waddr;
    ssti_pkg::vec3_t                pos_wdata, pos_new, acc_new;
    ssti_pkg::vel_row_t             vel_wdata;
    ssti_pkg::scl_req_t             req_acc, req_inc;

    assign start_w = s_tdata[226:131];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_acc   = s_tvalid & s_tready;
    assign trk_ext  = {4'b0, s_tdata[2:0]};
    assign in_range = (trk_ext < 7'(MAX_TRACKERS));
    assign in_addr  = trk_ext[ADDR_W-1:0];
    assign is_load  = in_acc & in_range & (s_tuser == ssti_pkg::REQ_LOAD);
    assign is_step  = in_acc & in_range & (s_tuser == ssti_pkg::REQ_STEP);

    assign unit_start   = (state_reg == ST_READ);
    assign vel_valid_rd = vel_valid_reg[addr_reg];
    assign wb = (state_reg == ST_CALC) && !(|busy_acc) && !(|busy_inc)
                && (!m_tvalid_reg || m_tready);

    assign inc_den = (step_reg == 32'd0) ? ssti_pkg::DEN_1 :
                     (step_reg == 32'd1) ? ssti_pkg::DEN_2 :
                     (step_reg == 32'd2) ? ssti_pkg::DEN_6 :
                     step_reg[0]         ? ssti_pkg::DEN_1 : ssti_pkg::DEN_3;

    assign req_acc.start = unit_start;
    assign req_acc.den   = ssti_pkg::DEN_1;
    assign req_inc.start = unit_start;
    assign req_inc.den   = inc_den;

    assign pos_we    = is_load | wb;
    assign pos_waddr = wb ? addr_reg : in_addr;
    assign pos_wdata = wb ? pos_new : ssti_pkg::vec3_t'(start_w);

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [31:0]                      shf, v, p, o, v_reg, p_reg;
        logic signed [ssti_pkg::NUM_W-1:0] v36, p36, o36, acc_num, inc_num;
        logic signed [ssti_pkg::RES_W-1:0] acc_res, inc_res;
        logic [36:0]                      pos_sum;

        assign shf = shift_reg[k];
        assign v   = (shf == 32'h8000_0000) ? 32'h7FFF_FFFF : (~shf + 32'd1);
        assign p   = vel_valid_rd ? vel_rd_reg.prev[k]  : 32'd0;
        assign o   = vel_valid_rd ? vel_rd_reg.older[k] : 32'd0;

        assign v36 = $signed({{4{v[31]}}, v});
        assign p36 = $signed({{4{p[31]}}, p});
        assign o36 = $signed({{4{o[31]}}, o});

        assign acc_num = v36 - p36;

        always_comb begin
            case (inc_den)
                ssti_pkg::DEN_1: inc_num = v36;
                ssti_pkg::DEN_2: inc_num = v36 - p36;
                ssti_pkg::DEN_6: inc_num = (v36 <<< 1) + (p36 <<< 2) + p36 - o36;
                default:         inc_num = v36 + p36 + o36;
            endcase
        end

        ssti_scale u_acc (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (req_acc),
            .num     (acc_num),
            .mult    (inv_reg),
            .busy    (busy_acc[k]),
            .result  (acc_res)
        );

        ssti_scale u_inc (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (req_inc),
            .num     (inc_num),
            .mult    (dt_reg),
            .busy    (busy_inc[k]),
            .result  (inc_res)
        );

        always_ff @(posedge aclk) begin
            if (unit_start) begin
                v_reg <= v;
                p_reg <= p;
            end
        end

        assign pos_sum = {{5{pos_rd_reg[k][31]}}, pos_rd_reg[k]}
                         + {inc_res[ssti_pkg::RES_W-1], inc_res};
        assign pos_new[k] = sat37(pos_sum);
        assign acc_new[k] = sat37({acc_res[ssti_pkg::RES_W-1], acc_res});

        assign vel_wdata.prev[k]  = v_reg;
        assign vel_wdata.older[k] = p_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (is_step) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: if (wb) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dt_reg        <= ssti_pkg::DEF_STEP;
            inv_reg       <= ssti_pkg::DEF_STEP;
            vel_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ssti_pkg::REG_TIME_STEP:
                        dt_reg  <= cfg_data[ssti_pkg::PARAM_W-1:0];
                    ssti_pkg::REG_INV_TIME_STEP:
                        inv_reg <= cfg_data[ssti_pkg::PARAM_W-1:0];
                    default: ;
                endcase
            end
            if (is_load) vel_valid_reg[in_addr] <= 1'b0;
            if (wb)      vel_valid_reg[addr_reg] <= 1'b1;
            if (wb) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_step) begin
            addr_reg  <= in_addr;
            trk_reg   <= s_tdata[2:0];
            step_reg  <= s_tdata[34:3];
            shift_reg <= s_tdata[130:35];
        end
        if (wb) begin
            m_tdata_reg <= {5'b0, acc_new[2], acc_new[1], acc_new[0],
                            pos_new[2], pos_new[1], pos_new[0], trk_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we)  pos_mem[pos_waddr] <= pos_wdata;
        if (is_step) pos_rd_reg <= pos_mem[in_addr];
        if (wb)      vel_mem[addr_reg] <= vel_wdata;
        if (is_step) vel_rd_reg <= vel_mem[in_addr];
    end

endmodule
